// ===== rtl/core/cpmd_pkg.sv =====
`timescale 1ns / 1ps
package cpmd_pkg;

	localparam int LENGTH_WIDTH = 24;
	localparam int HOLD_DEPTH = 256;
	localparam int HOLD_AW = $clog2(HOLD_DEPTH);
	localparam int MASK_DEPTH = 32;
	localparam int MASK_AW = $clog2(MASK_DEPTH);
	localparam int CFG_INDEX_WIDTH = 1;

	typedef logic [LENGTH_WIDTH-1:0] cpmd_pos_t;
	typedef logic [MASK_DEPTH-1:0][7:0] cpmd_table_t;

	localparam cpmd_pos_t OFFSET_MAX = '1;
	localparam cpmd_pos_t CLEAR_HEAD = cpmd_pos_t'(32'h40);
	localparam cpmd_pos_t UNMASK_START = cpmd_pos_t'(32'h140);
	localparam cpmd_pos_t VIDEO_MIN_LEN = cpmd_pos_t'(32'h240);
	localparam cpmd_pos_t HELD_LAG = cpmd_pos_t'(32'h100);

	localparam logic [1:0] FUNC_PASS = 2'd0;
	localparam logic [1:0] FUNC_VIDEO = 2'd1;
	localparam logic [1:0] FUNC_AUDIO = 2'd2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_LOW = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_HIGH = 1'b1;

	localparam logic [31:0] KEY_LOW_RESET = 32'hF27E3B22;
	localparam logic [31:0] KEY_HIGH_RESET = 32'h00003657;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_in;
		logic [LENGTH_WIDTH-1:0] chunk_length;
		logic chunk_start;
	} cpmd_in_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [LENGTH_WIDTH-1:0] byte_position;
		logic result_last;
	} cpmd_out_t;

	typedef struct packed {
		logic start;
		logic scr;
		logic [1:0] kind;
		logic [7:0] data;
		cpmd_pos_t pos;
	} cpmd_stage_t;

	function automatic cpmd_table_t cpmd_derive(input logic [31:0] key_low,
			input logic [31:0] key_high);
		cpmd_table_t t;
		t[5'h00] = key_low[7:0];
		t[5'h01] = key_low[15:8];
		t[5'h02] = key_low[23:16];
		t[5'h03] = key_low[31:24] - 8'h34;
		t[5'h04] = key_high[7:0] + 8'hF9;
		t[5'h05] = key_high[15:8] ^ 8'h13;
		t[5'h06] = key_high[23:16] + 8'h61;
		t[5'h07] = t[5'h00] ^ 8'hFF;
		t[5'h08] = t[5'h02] + t[5'h01];
		t[5'h09] = t[5'h01] - t[5'h07];
		t[5'h0A] = t[5'h02] ^ 8'hFF;
		t[5'h0B] = t[5'h01] ^ 8'hFF;
		t[5'h0C] = t[5'h0B] + t[5'h09];
		t[5'h0D] = t[5'h08] - t[5'h03];
		t[5'h0E] = t[5'h0D] ^ 8'hFF;
		t[5'h0F] = t[5'h0A] - t[5'h0B];
		t[5'h10] = t[5'h08] - t[5'h0F];
		t[5'h11] = t[5'h10] ^ t[5'h07];
		t[5'h12] = t[5'h0F] ^ 8'hFF;
		t[5'h13] = t[5'h03] ^ 8'h10;
		t[5'h14] = t[5'h04] - 8'h32;
		t[5'h15] = t[5'h05] + 8'hED;
		t[5'h16] = t[5'h06] ^ 8'hF3;
		t[5'h17] = t[5'h13] - t[5'h0F];
		t[5'h18] = t[5'h15] + t[5'h07];
		t[5'h19] = 8'h21 - t[5'h13];
		t[5'h1A] = t[5'h14] ^ t[5'h17];
		t[5'h1B] = t[5'h16] + t[5'h16];
		t[5'h1C] = t[5'h17] + 8'h44;
		t[5'h1D] = t[5'h03] + t[5'h04];
		t[5'h1E] = t[5'h05] - t[5'h16];
		t[5'h1F] = t[5'h1D] ^ t[5'h13];
		return t;
	endfunction

	function automatic logic [7:0] cpmd_audio_tag(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h55;
			2'd1: c = 8'h52;
			2'd2: c = 8'h55;
			2'd3: c = 8'h43;
			default: c = 8'h55;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/cpmd_key_table.sv =====
`timescale 1ns / 1ps
module cpmd_key_table (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cpmd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output cpmd_pkg::cpmd_table_t mask_table_q
);
	import cpmd_pkg::*;

	logic [31:0] key_low_q;
	logic [31:0] key_high_q;
	logic [31:0] low_nxt;
	logic [31:0] high_nxt;

	assign cfg_ready = 1'b1;

	always_comb begin
		low_nxt = key_low_q;
		high_nxt = key_high_q;
		case (cfg_index)
			REG_KEY_LOW: low_nxt = cfg_data;
			REG_KEY_HIGH: high_nxt = cfg_data;
			default: begin
			end
		endcase
	end

	// table is rederived together with the key write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= KEY_LOW_RESET;
			key_high_q <= KEY_HIGH_RESET;
			mask_table_q <= cpmd_derive(KEY_LOW_RESET, KEY_HIGH_RESET);
		end else if (cfg_valid) begin
			key_low_q <= low_nxt;
			key_high_q <= high_nxt;
			mask_table_q <= cpmd_derive(low_nxt, high_nxt);
		end
	end

endmodule

// ===== rtl/core/cpmd_front.sv =====
`timescale 1ns / 1ps
module cpmd_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input cpmd_pkg::cpmd_in_t item,
	input logic take,
	output logic stage_valid_s1,
	output cpmd_pkg::cpmd_stage_t stage_s1,
	output logic [7:0] held_s1
);
	import cpmd_pkg::*;

	logic [7:0] hold_mem [HOLD_DEPTH];
	cpmd_pos_t off_q;
	logic [1:0] kind_q;
	logic scr_q;

	logic acc;
	cpmd_pos_t pos_in;
	logic [1:0] kind_in;
	logic scr_in;
	logic [HOLD_AW-1:0] hold_addr;
	logic hold_wr;

	assign item_ready = !stage_valid_s1 || take;
	assign acc = item_valid && item_ready;

	always_comb begin
		if (item.chunk_start) begin
			pos_in = '0;
			kind_in = item.func;
			scr_in = (item.func == FUNC_AUDIO) ||
				(item.func == FUNC_VIDEO && item.chunk_length >= VIDEO_MIN_LEN);
		end else begin
			pos_in = off_q;
			kind_in = kind_q;
			scr_in = scr_q;
		end
	end

	// held byte and its partner 0x100 later share one address
	assign hold_addr = pos_in[HOLD_AW-1:0] - CLEAR_HEAD[HOLD_AW-1:0];
	assign hold_wr = acc && scr_in && kind_in == FUNC_VIDEO &&
		pos_in >= CLEAR_HEAD && pos_in < UNMASK_START;

	always_ff @(posedge clk) begin
		if (hold_wr) begin
			hold_mem[hold_addr] <= item.data_in;
		end
		if (acc) begin
			held_s1 <= hold_mem[hold_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			kind_q <= FUNC_PASS;
			scr_q <= 1'b0;
			stage_valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				off_q <= (pos_in == OFFSET_MAX) ? OFFSET_MAX : pos_in + 1'b1;
				kind_q <= kind_in;
				scr_q <= scr_in;
				stage_valid_s1 <= 1'b1;
			end else if (take) begin
				stage_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stage_s1.start <= item.chunk_start;
			stage_s1.scr <= scr_in;
			stage_s1.kind <= kind_in;
			stage_s1.data <= item.data_in;
			stage_s1.pos <= pos_in;
		end
	end

endmodule

// ===== rtl/core/cpmd_unmask.sv =====
`timescale 1ns / 1ps
module cpmd_unmask (
	input logic clk,
	input logic arst_n,
	input logic stage_valid_s1,
	input cpmd_pkg::cpmd_stage_t stage_s1,
	input logic [7:0] held_s1,
	input cpmd_pkg::cpmd_table_t mask_table,
	output logic take,
	output logic result_valid,
	input logic result_ready,
	output cpmd_pkg::cpmd_out_t result
);
	import cpmd_pkg::*;

	logic [7:0] fb_q [MASK_DEPTH];
	logic [7:0] lm_q [MASK_DEPTH];
	cpmd_out_t res0_q;
	cpmd_out_t res1_q;
	logic [1:0] cnt_q;

	logic [MASK_AW-1:0] k;
	logic clear;
	logic audio;
	logic [7:0] d_fb;
	logic [7:0] lm_nxt;
	logic [7:0] audio_mask;
	logic fb_wr;
	logic lm_wr;
	cpmd_out_t res_a;
	cpmd_out_t res_b;
	logic [1:0] nres;
	logic pop;

	assign k = stage_s1.pos[MASK_AW-1:0];
	assign clear = !stage_s1.scr || stage_s1.pos < CLEAR_HEAD;
	assign audio = stage_s1.kind == FUNC_AUDIO;
	assign d_fb = stage_s1.data ^ fb_q[k];
	assign lm_nxt = lm_q[k] ^ d_fb;
	assign audio_mask = k[0] ? cpmd_audio_tag(k[2:1]) : (mask_table[k] ^ 8'hFF);

	assign pop = result_valid && result_ready;
	assign take = stage_valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && result_ready));

	always_comb begin
		res_a.data_out = stage_s1.data;
		res_a.byte_position = stage_s1.pos;
		res_a.result_last = 1'b1;
		res_b = res_a;
		nres = 2'd1;
		fb_wr = 1'b0;
		lm_wr = 1'b0;
		if (clear) begin
			nres = 2'd1;
		end else if (audio) begin
			if (stage_s1.pos >= UNMASK_START) begin
				res_a.data_out = stage_s1.data ^ audio_mask;
			end
		end else if (stage_s1.pos < UNMASK_START) begin
			nres = 2'd0;
		end else begin
			fb_wr = 1'b1;
			if (stage_s1.pos < VIDEO_MIN_LEN) begin
				lm_wr = 1'b1;
				res_a.data_out = held_s1 ^ lm_nxt;
				res_a.byte_position = stage_s1.pos - HELD_LAG;
				res_a.result_last = 1'b0;
				res_b.data_out = d_fb;
				nres = 2'd2;
			end else begin
				res_a.data_out = d_fb;
			end
		end
	end

	// running masks restart from the table on each chunk start
	always_ff @(posedge clk) begin
		if (take && stage_s1.start) begin
			for (int i = 0; i < MASK_DEPTH; i++) begin
				lm_q[i] <= mask_table[i];
				fb_q[i] <= mask_table[i] ^ 8'hFF;
			end
		end else if (take) begin
			if (fb_wr) begin
				fb_q[k] <= d_fb ^ mask_table[k] ^ 8'hFF;
			end
			if (lm_wr) begin
				lm_q[k] <= lm_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (take) begin
			cnt_q <= nres;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res0_q <= res_a;
			res1_q <= res_b;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign result_valid = cnt_q != 2'd0;
	assign result = res0_q;

endmodule

// ===== rtl/core/chunk_payload_mask_descrambler.sv =====
`timescale 1ns / 1ps
// path: an accepted request is registered in the front stage, then loaded into the result
// register when the unmask stage takes it, which waits while results are still pending
// throughput: one byte per cycle while result_ready is high; a video byte at 0x140..0x23F
// gives two results on the single result port; the next byte waits until one is popped
// reset: offset, chunk kind and all valid state clear; keys return to their reset values
// and the mask table is rederived from them
module chunk_payload_mask_descrambler (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input cpmd_pkg::cpmd_in_t item,
	output logic result_valid,
	input logic result_ready,
	output cpmd_pkg::cpmd_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cpmd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import cpmd_pkg::*;

	cpmd_table_t mask_table;
	logic take;
	logic stage_valid_s1;
	cpmd_stage_t stage_s1;
	logic [7:0] held_s1;

	cpmd_key_table u_key_table (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mask_table_q(mask_table)
	);

	cpmd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.take(take),
		.stage_valid_s1(stage_valid_s1),
		.stage_s1(stage_s1),
		.held_s1(held_s1)
	);

	cpmd_unmask u_unmask (
		.clk(clk),
		.arst_n(arst_n),
		.stage_valid_s1(stage_valid_s1),
		.stage_s1(stage_s1),
		.held_s1(held_s1),
		.mask_table(mask_table),
		.take(take),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

// ===== rtl/core/cpmd_checker.sv =====
`timescale 1ns / 1ps
module cpmd_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input cpmd_pkg::cpmd_out_t result
);
	import cpmd_pkg::*;

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a held byte is always followed by its partner
	a_partner_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.result_last |=> result_valid)
		else $error("partner result missing after held byte");

	a_partner_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.result_last |=>
		result.byte_position == LENGTH_WIDTH'($past(result.byte_position) + HELD_LAG))
		else $error("partner position mismatch");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.result_last |->
		result.byte_position >= CLEAR_HEAD && result.byte_position < UNMASK_START)
		else $error("held byte outside held window");

endmodule

bind chunk_payload_mask_descrambler cpmd_checker u_cpmd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
